FILE: rtl/umpq_pkg.sv
// ----------------------------------------------------------------------------
// umpq_pkg
// Shared types and constants for the unsorted min-priority queue: request and
// result beats, action and status codes, controller states and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package umpq_pkg;

  // fixed field widths
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned ENTRY_W = KEY_W + PRIO_W;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_UPDATE  = 2'd2,
    ACT_EXTRACT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_TAIL,
    S_MOVE,
    S_DONE
  } state_e;

  // request beat
  typedef struct packed {
    action_e                   action;
    logic [KEY_W-1:0]          key;
    logic signed [PRIO_W-1:0]  priority_req;
  } req_t;

  // result beat
  typedef struct packed {
    logic [KEY_W-1:0]    key_out;
    logic                hit;
    status_e             status;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic dispatch;  // settle status, clear scan state
    logic ins_wr;    // append latched pair
    logic rd_issue;  // scan read at index counter
    logic tail_rd;   // read last entry
    logic move_wr;   // move last entry into freed slot
    logic out_load;  // capture result beat
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e action;
    logic    full;
    logic    empty;
    logic    last_issue;
  } dp_sts_t;

endpackage : umpq_pkg

`default_nettype wire

FILE: rtl/umpq_ram.sv
// ----------------------------------------------------------------------------
// umpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : umpq_ram

`default_nettype wire

FILE: rtl/umpq_ctrl.sv
// ----------------------------------------------------------------------------
// umpq_ctrl
// Controller state machine: sequences insert, scan, tail read and move, and
// owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire umpq_pkg::dp_sts_t sts_i,
  output umpq_pkg::dp_cmd_t      cmd_o
);

  import umpq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts_i.action == ACT_INSERT || sts_i.empty) state_d = S_DONE;
        else                                           state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.last_issue) state_d = S_TAIL;
      end
      S_TAIL: begin
        if (sts_i.action == ACT_EXTRACT) state_d = S_MOVE;
        else                             state_d = S_DONE;
      end
      S_MOVE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        cmd_o.ins_wr   = (sts_i.action == ACT_INSERT) && !sts_i.full;
      end
      S_SCAN: begin
        cmd_o.rd_issue = 1'b1;
      end
      S_TAIL: begin
        cmd_o.tail_rd = (sts_i.action == ACT_EXTRACT);
      end
      S_MOVE: begin
        cmd_o.move_wr = 1'b1;
      end
      S_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : umpq_ctrl

`default_nettype wire

FILE: rtl/umpq_dp.sv
// ----------------------------------------------------------------------------
// umpq_dp
// Datapath: entry RAM, fill count, scan index, match and minimum tracking,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire umpq_pkg::req_t    req_i,
  input  wire umpq_pkg::dp_cmd_t cmd_i,
  output umpq_pkg::dp_sts_t      sts_o,
  output umpq_pkg::rsp_t         rsp_o
);

  import umpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  req_t                     req_q;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic                     scan_vld_q;
  logic [AW-1:0]            scan_idx_q;
  logic                     hit_q, hit_d;
  logic [AW-1:0]            best_idx_q, best_idx_d;
  logic signed [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic [KEY_W-1:0]         best_key_q, best_key_d;
  status_e                  status_q, status_d;
  rsp_t                     rsp_q;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ENTRY_W-1:0]       wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [ENTRY_W-1:0]       rdata;
  logic [KEY_W-1:0]         rd_key;
  logic signed [PRIO_W-1:0] rd_prio;
  logic                     key_match;
  logic [CW-1:0]            count_m1;
  logic [CW-1:0]            idx_p1;
  logic [CW+COUNT_W-1:0]    count_ext;

  assign rd_key    = rdata[ENTRY_W-1:PRIO_W];
  assign rd_prio   = $signed(rdata[PRIO_W-1:0]);
  assign key_match = (rd_key == req_q.key);
  assign count_m1  = count_q - CW'(1);
  assign idx_p1    = CW'(idx_q) + CW'(1);
  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  // status toward the controller
  assign sts_o.action     = req_q.action;
  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.last_issue = (idx_p1 == count_q);

  // ram port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.ins_wr) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = {req_q.key, req_q.priority_req};
    end else if (cmd_i.move_wr) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = rdata;
    end else if (scan_vld_q && req_q.action == ACT_UPDATE && key_match) begin
      we    = 1'b1;
      waddr = scan_idx_q;
      wdata = {rd_key, req_q.priority_req};
    end
  end

  assign re    = cmd_i.rd_issue || cmd_i.tail_rd;
  assign raddr = cmd_i.tail_rd ? count_m1[AW-1:0] : idx_q;

  umpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // fill count
  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_wr)  count_d = count_q + CW'(1);
    if (cmd_i.move_wr) count_d = count_m1;
  end

  // scan index, status, query hit and running minimum
  always_comb begin
    idx_d       = idx_q;
    hit_d       = hit_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    best_key_d  = best_key_q;
    status_d    = status_q;
    if (cmd_i.dispatch) begin
      idx_d = '0;
      hit_d = 1'b0;
      if (req_q.action == ACT_INSERT && sts_o.full)        status_d = ST_FULL;
      else if (req_q.action == ACT_EXTRACT && sts_o.empty) status_d = ST_EMPTY;
      else                                                 status_d = ST_OK;
    end
    if (cmd_i.rd_issue) idx_d = idx_q + AW'(1);
    if (scan_vld_q) begin
      if (key_match) hit_d = 1'b1;
      // strict less keeps the lowest index on ties
      if (scan_idx_q == '0 || rd_prio < best_prio_q) begin
        best_idx_d  = scan_idx_q;
        best_prio_d = rd_prio;
        best_key_d  = rd_key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_vld_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_vld_q <= cmd_i.rd_issue;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    scan_idx_q  <= idx_q;
    idx_q       <= idx_d;
    hit_q       <= hit_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_key_q  <= best_key_d;
    status_q    <= status_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.key_out     <= (req_q.action == ACT_EXTRACT && status_q == ST_OK) ?
                           best_key_q : '0;
      rsp_q.hit         <= (req_q.action == ACT_QUERY) ? hit_q :
                           (req_q.action == ACT_EXTRACT && status_q == ST_OK);
      rsp_q.status      <= status_q;
      rsp_q.is_empty    <= (count_q == '0);
      rsp_q.entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign rsp_o = rsp_q;

endmodule : umpq_dp

`default_nettype wire

FILE: rtl/unsorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// unsorted_min_priority_queue
// Min-priority queue held as an unsorted array of key and priority pairs in
// one RAM, with insert, membership query, priority update and extract-min.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+--------
//   in      | input     | in_valid_i/in_ready_o | req_t
//   out     | output    | out_valid_o/out_ready_i | rsp_t
//
// The scan for query, update and extract reads one entry a cycle through the
// single RAM read port; insert needs no scan. One request is in flight at a
// time. Reset clears the fill count, the scan flag and the handshake flags
// only; the RAM is never cleared. A stalled result holds in the output
// register; the next request is accepted meanwhile and waits only at its own
// result.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_min_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire umpq_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output umpq_pkg::rsp_t      out_rsp_o
);

  import umpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  umpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  umpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule : unsorted_min_priority_queue

`default_nettype wire

FILE: rtl/umpq_checker.sv
// ----------------------------------------------------------------------------
// umpq_checker
// Port-level assertions for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire umpq_pkg::rsp_t out_rsp_o
);

  import umpq_pkg::*;

  // one request in flight: accept drops ready
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result beat changed");

  // a new result comes only as the request side frees up
  a_rise_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while a request was still busy");

  // empty extract reports nothing taken
  a_empty_extract: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_EMPTY |->
      out_rsp_o.is_empty && !out_rsp_o.hit && out_rsp_o.key_out == '0)
    else $error("extract on empty queue returned data");

  // rejected insert leaves a full queue
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_FULL |->
      !out_rsp_o.is_empty && !out_rsp_o.hit)
    else $error("rejected insert with inconsistent flags");

endmodule : umpq_checker

bind unsorted_min_priority_queue umpq_checker u_umpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

FILE: bench/unsorted_min_priority_queue_test.sv
// ----------------------------------------------------------------------------
// unsorted_min_priority_queue_test
// Self-checking bench for the unsorted min-priority queue. Request beats go in
// through a valid/ready sender with random gaps. A model of the array in the
// bench predicts each result beat when its request is accepted. A checker
// compares every result beat field by field, in order. The tests cover the
// empty and full queue, duplicate keys and priority ties, a long result
// hold-off, and a long random mix.
// ----------------------------------------------------------------------------

module unsorted_min_priority_queue_test;
  import umpq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int IDLE_PCT     = 14;
  localparam int HOLDOFF_CYCS = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 2 * QUEUE_DEPTH + 16;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_req    = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rsp_t out_rsp;

  // shadow copy of the queue contents
  logic [KEY_W-1:0]         held_keys  [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] held_prios [QUEUE_DEPTH];
  int                       held_count = 0;

  rsp_t predicted_rsp_q [$];
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  bit   steady_flow  = 1'b0;
  bit   holdoff_req  = 1'b0;

  unsorted_min_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // apply one request to the shadow queue and return its result beat
  function automatic rsp_t predict_queue_op(input req_t r);
    rsp_t rsp;
    int   best;
    rsp        = '0;
    rsp.status = ST_OK;
    case (r.action)
      ACT_INSERT: begin
        if (held_count >= QUEUE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          held_keys[held_count]  = r.key;
          held_prios[held_count] = r.priority_req;
          held_count++;
        end
      end
      ACT_QUERY: begin
        for (int i = 0; i < held_count; i++)
          if (held_keys[i] == r.key) rsp.hit = 1'b1;
      end
      ACT_UPDATE: begin
        for (int i = 0; i < held_count; i++)
          if (held_keys[i] == r.key) held_prios[i] = r.priority_req;
      end
      default: begin
        if (held_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          // lowest priority, first index on ties
          best = 0;
          for (int i = 1; i < held_count; i++)
            if (held_prios[i] < held_prios[best]) best = i;
          rsp.key_out = held_keys[best];
          rsp.hit     = 1'b1;
          held_keys[best]  = held_keys[held_count-1];
          held_prios[best] = held_prios[held_count-1];
          held_count--;
        end
      end
    endcase
    rsp.is_empty    = (held_count == 0);
    rsp.entry_count = COUNT_W'(held_count);
    return rsp;
  endfunction

  // keys: often one already held, often a small pool, else anything
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40 && held_count > 0) return held_keys[$urandom_range(held_count - 1)];
    if (sel < 70) return KEY_W'($urandom_range(7));
    return KEY_W'($urandom_range(16'hFFFF));
  endfunction

  // priorities: narrow band for ties, the extremes, else full range
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return PRIO_W'($signed($urandom_range(8)) - 4);
    if (sel < 40) begin
      case ($urandom_range(3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    return PRIO_W'($urandom);
  endfunction

  // random request; query and update share what insert and extract leave
  function automatic req_t random_req(input int insert_pct, input int extract_pct);
    req_t r;
    int   sel;
    sel            = $urandom_range(99);
    r.key          = pick_key();
    r.priority_req = pick_prio();
    if (sel < insert_pct)                    r.action = ACT_INSERT;
    else if (sel < insert_pct + extract_pct) r.action = ACT_EXTRACT;
    else if (sel[0])                         r.action = ACT_QUERY;
    else                                     r.action = ACT_UPDATE;
    return r;
  endfunction

  // send one request beat, with random idle cycles ahead of it unless steady flow is set
  task automatic send_req(input req_t r);
    @(negedge clk_i);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predicted_rsp_q.push_back(predict_queue_op(r));
  endtask

  task automatic send_op(input action_e act, input logic [KEY_W-1:0] key,
                         input logic signed [PRIO_W-1:0] prio);
    req_t r;
    r.action       = act;
    r.key          = key;
    r.priority_req = prio;
    send_req(r);
  endtask

  // stop sending until every result beat is back
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // empty queue, extreme keys and priorities, duplicates and ties
  task automatic test_corner_cases();
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_QUERY,   16'h0000, '0);
    send_op(ACT_UPDATE,  16'h0000, 32'sh1234_5678);
    send_op(ACT_INSERT,  16'hFFFF, 32'sh7FFF_FFFF);
    send_op(ACT_INSERT,  16'h0000, 32'sh8000_0000);
    send_op(ACT_INSERT,  16'h5A5A, '0);
    send_op(ACT_INSERT,  16'h5A5A, '0);
    send_op(ACT_INSERT,  16'hA5A5, -32'sd5);
    send_op(ACT_QUERY,   16'hFFFF, '0);
    send_op(ACT_QUERY,   16'h1234, '0);
    send_op(ACT_UPDATE,  16'h5A5A, -32'sd5);
    send_op(ACT_UPDATE,  16'hBEEF, 32'sh8000_0000);
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_QUERY,   16'h5A5A, '0);
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_EXTRACT, 16'h0000, '0);
    send_op(ACT_QUERY,   16'hFFFF, '0);
    wait_results_drained();
  endtask

  // fill to capacity, push inserts against the full queue, then drain
  task automatic test_fill_and_drain();
    for (int round = 0; round < 3; round++) begin
      while (held_count < QUEUE_DEPTH) send_req(random_req(85, 5));
      for (int i = 0; i < 4; i++) begin
        send_op(ACT_INSERT, pick_key(), pick_prio());
        send_req(random_req(0, 0));
      end
      while (held_count > 0) send_req(random_req(5, 85));
      wait_results_drained();
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_result_holdoff();
    holdoff_req = 1'b1;
    for (int i = 0; i < 40; i++) send_req(random_req(60, 10));
    wait_results_drained();
  endtask

  // long random mix, middle stretch without idle cycles
  task automatic test_random_mix();
    for (int i = 0; i < 400; i++) send_req(random_req(30, 25));
    steady_flow = 1'b1;
    for (int i = 0; i < 300; i++) send_req(random_req(30, 25));
    steady_flow = 1'b0;
    for (int i = 0; i < 380; i++) send_req(random_req(30, 25));
    wait_results_drained();
  endtask

  // result side ready, with random stalls and the requested hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCS) @(negedge clk_i);
        holdoff_req = 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (predicted_rsp_q.size() == 0) begin
        $display("%0t: result beat with none pending, expected nothing, got %p",
                 $time, out_rsp);
        mismatches++;
      end else begin
        want = predicted_rsp_q.pop_front();
        check_field("key_out",     want.key_out,     out_rsp.key_out);
        check_field("hit",         want.hit,         out_rsp.hit);
        check_field("status",      want.status,      out_rsp.status);
        check_field("is_empty",    want.is_empty,    out_rsp.is_empty);
        check_field("entry_count", want.entry_count, out_rsp.entry_count);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_cases();
    test_fill_and_drain();
    test_result_holdoff();
    test_random_mix();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
